### hdl/text_line_format_checker_defines.svh
// ---------------------------------------------------------------------------
// Text line format checker: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_FORMAT_CHECKER_DEFINES_SVH
`define TEXT_LINE_FORMAT_CHECKER_DEFINES_SVH

// same-cycle implication
`define TLFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tlfc_pkg.sv
// ---------------------------------------------------------------------------
// tlfc_pkg
// Widths, report codes, state/result types and report ordering.
// ---------------------------------------------------------------------------
package tlfc_pkg;

    localparam int LINE_NUMBER_WIDTH = 32;
    localparam int LINE_OUT_W        = 32;
    localparam int POS_W             = 21;
    localparam int CODE_W            = 4;
    localparam int REPORT_N          = 9;

    localparam logic [POS_W-1:0] LIMIT_RESET = POS_W'(1048576);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // report codes
    localparam logic [CODE_W-1:0] RC_NONPRINT   = 4'd0;
    localparam logic [CODE_W-1:0] RC_TAB_LIKE   = 4'd1;
    localparam logic [CODE_W-1:0] RC_DOUBLE_WS  = 4'd2;
    localparam logic [CODE_W-1:0] RC_LEAD_WS    = 4'd3;
    localparam logic [CODE_W-1:0] RC_TRAIL_WS   = 4'd4;
    localparam logic [CODE_W-1:0] RC_EMPTY      = 4'd5;
    localparam logic [CODE_W-1:0] RC_NO_NEWLINE = 4'd6;
    localparam logic [CODE_W-1:0] RC_TOO_LONG   = 4'd7;
    localparam logic [CODE_W-1:0] RC_DONE       = 4'd8;

    typedef logic [REPORT_N-1:0] report_mask_t;

    typedef struct packed {
        logic [LINE_NUMBER_WIDTH-1:0] current_line;
        logic [POS_W-1:0]             line_position;
        logic                         prev_ws;
        logic                         too_long;
        logic                         error_seen;
    } line_state_t;

    typedef struct packed {
        report_mask_t mask;
        logic         all_passed;
    } eval_res_t;

    // Pending report that goes out next, in detection order:
    // lead ws, nonprint, tab-like, double ws, no newline, empty, trail ws,
    // too long, done.
    function automatic logic [CODE_W-1:0] next_code(input report_mask_t m);
        logic [CODE_W-1:0] c;
        c = RC_DONE;
        if (m[RC_LEAD_WS])
            c = RC_LEAD_WS;
        else if (m[RC_NONPRINT])
            c = RC_NONPRINT;
        else if (m[RC_TAB_LIKE])
            c = RC_TAB_LIKE;
        else if (m[RC_DOUBLE_WS])
            c = RC_DOUBLE_WS;
        else if (m[RC_NO_NEWLINE])
            c = RC_NO_NEWLINE;
        else if (m[RC_EMPTY])
            c = RC_EMPTY;
        else if (m[RC_TRAIL_WS])
            c = RC_TRAIL_WS;
        else if (m[RC_TOO_LONG])
            c = RC_TOO_LONG;
        return c;
    endfunction

endpackage

### hdl/tlfc_eval.sv
// ---------------------------------------------------------------------------
// tlfc_eval
// Per-word checks: report set and next line state for one input word.
// ---------------------------------------------------------------------------
module tlfc_eval (
    input  logic                          kind,
    input  logic [7:0]                    data_byte,
    input  logic [tlfc_pkg::POS_W-1:0]    limit,
    input  tlfc_pkg::line_state_t         st,
    output tlfc_pkg::line_state_t         st_next,
    output tlfc_pkg::eval_res_t           res
);

    logic is_ws;
    logic is_nl;
    logic nonprint;
    logic pos_zero;
    tlfc_pkg::report_mask_t m;

    assign is_ws    = (data_byte == tlfc_pkg::CH_SPACE) ||
                      ((data_byte >= tlfc_pkg::CH_TAB) && (data_byte <= tlfc_pkg::CH_CR));
    assign is_nl    = (data_byte == tlfc_pkg::CH_NEWLINE);
    assign nonprint = (data_byte < tlfc_pkg::CH_SPACE) || (data_byte > tlfc_pkg::CH_TILDE);
    assign pos_zero = (st.line_position == '0);

    always_comb
    begin
        m       = '0;
        st_next = st;
        res.all_passed = 1'b0;
        if (kind == tlfc_pkg::KIND_EOS)
        begin
            if (!pos_zero)
            begin
                m[tlfc_pkg::RC_NO_NEWLINE] = 1'b1;
                if (!st.too_long && st.prev_ws)
                    m[tlfc_pkg::RC_TRAIL_WS] = 1'b1;
            end
            m[tlfc_pkg::RC_DONE] = 1'b1;
            res.all_passed = !(st.error_seen || !pos_zero);
            st_next.current_line  = tlfc_pkg::LINE_NUMBER_WIDTH'(1);
            st_next.line_position = '0;
            st_next.prev_ws       = 1'b0;
            st_next.too_long      = 1'b0;
            st_next.error_seen    = 1'b0;
        end
        else
        begin
            if (st.line_position >= limit)
            begin
                // only the first byte past the limit reports
                if (!st.too_long)
                begin
                    st_next.too_long = 1'b1;
                    m[tlfc_pkg::RC_TOO_LONG] = 1'b1;
                end
            end
            else if (is_nl)
            begin
                if (pos_zero)
                    m[tlfc_pkg::RC_EMPTY] = 1'b1;
                else if (st.prev_ws)
                    m[tlfc_pkg::RC_TRAIL_WS] = 1'b1;
            end
            else
            begin
                m[tlfc_pkg::RC_LEAD_WS]   = pos_zero && is_ws;
                m[tlfc_pkg::RC_NONPRINT]  = nonprint;
                m[tlfc_pkg::RC_TAB_LIKE]  = is_ws && (data_byte != tlfc_pkg::CH_SPACE);
                m[tlfc_pkg::RC_DOUBLE_WS] = !pos_zero && is_ws && st.prev_ws;
            end

            if (is_nl)
            begin
                if (!(&st.current_line))
                    st_next.current_line = st.current_line + 1'b1;
                st_next.line_position = '0;
                st_next.prev_ws       = 1'b0;
                st_next.too_long      = 1'b0;
            end
            else
            begin
                st_next.prev_ws = is_ws;
                if (!(&st.line_position))
                    st_next.line_position = st.line_position + 1'b1;
            end
            st_next.error_seen = st.error_seen || (m != '0);
        end
        res.mask = m;
    end

endmodule

### hdl/text_line_format_checker.sv
// Pipeline: an accepted word passes the input register, then the report register, where its
//   first report is offered; further reports follow one per cycle while out_stall is low.
// Throughput: one word per cycle while each word gives at most one report and out_stall
//   is low; a word with k reports holds the report register until all k are taken
//   (k is at most 3).
// Reset (rst_n low, asynchronous): line 1, position 0, flags clear, limit 1048576,
//   both registers empty. No memories, no clearing pass.
// ---------------------------------------------------------------------------
// text_line_format_checker
// Byte-stream text format checker with in-order error reports.
// ---------------------------------------------------------------------------
`include "text_line_format_checker_defines.svh"

module text_line_format_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: longest allowed line, newline included
    input  logic                               cfg_we,
    input  logic [tlfc_pkg::POS_W-1:0]         cfg_wdata,
    // input words
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [7:0]                         data_byte,
    // report words
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tlfc_pkg::CODE_W-1:0]        report_code,
    output logic [tlfc_pkg::LINE_OUT_W-1:0]    line_number,
    output logic [tlfc_pkg::POS_W-1:0]         position,
    output logic                               all_passed,
    output logic                               last
);

    // configuration register
    logic [tlfc_pkg::POS_W-1:0] limit_reg;

    // input register: holds one accepted word until its reports can be staged
    logic       a_valid_reg, a_valid_next;
    logic       a_kind_reg;
    logic [7:0] a_byte_reg;

    // stream state
    tlfc_pkg::line_state_t st_reg, st_next;

    // report register: pending report set of one word plus shared fields
    tlfc_pkg::report_mask_t              b_mask_reg, b_mask_next;
    logic [tlfc_pkg::LINE_NUMBER_WIDTH-1:0] b_line_reg;
    logic [tlfc_pkg::POS_W-1:0]          b_pos_reg;
    logic                                b_pass_reg;

    tlfc_pkg::eval_res_t res;
    logic in_acc;
    logic out_acc;
    logic b_single;
    logic b_free;
    logic a_move;
    logic b_load;
    logic [tlfc_pkg::CODE_W-1:0] sel_code;

    tlfc_eval u_eval (
        .kind      (a_kind_reg),
        .data_byte (a_byte_reg),
        .limit     (limit_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .res       (res)
    );

    // --- handshakes --------------------------------------------------------
    assign out_valid = (b_mask_reg != '0);
    assign out_acc   = out_valid && !out_stall;
    // exactly one pending report left
    assign b_single  = out_valid && ((b_mask_reg & (b_mask_reg - 1'b1)) == '0);
    // report register can take a new set this cycle
    assign b_free    = !out_valid || (out_acc && b_single);
    // a word that gives no report only updates the state and never waits
    assign a_move    = a_valid_reg && ((res.mask == '0) || b_free);
    assign b_load    = a_move && (res.mask != '0);
    assign in_stall  = a_valid_reg && !a_move;
    assign in_acc    = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_acc)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;
    end

    // --- report sequencing ---------------------------------------------------
    assign sel_code = tlfc_pkg::next_code(b_mask_reg);

    always_comb
    begin
        b_mask_next = b_mask_reg;
        if (b_load)
            b_mask_next = res.mask;
        else if (out_acc)
            b_mask_next = b_mask_reg & ~(tlfc_pkg::REPORT_N'(1) << sel_code);
    end

    assign report_code = sel_code;
    assign line_number = tlfc_pkg::LINE_OUT_W'(b_line_reg);
    assign position    = b_pos_reg;
    assign all_passed  = b_pass_reg && (sel_code == tlfc_pkg::RC_DONE);
    assign last        = b_single;

    // --- registers -----------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= tlfc_pkg::LIMIT_RESET;
            a_valid_reg <= 1'b0;
            b_mask_reg  <= '0;
            st_reg.current_line  <= tlfc_pkg::LINE_NUMBER_WIDTH'(1);
            st_reg.line_position <= '0;
            st_reg.prev_ws       <= 1'b0;
            st_reg.too_long      <= 1'b0;
            st_reg.error_seen    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            a_valid_reg <= a_valid_next;
            b_mask_reg  <= b_mask_next;
            if (a_move)
                st_reg <= st_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_kind_reg <= kind;
            a_byte_reg <= data_byte;
        end
        if (b_load)
        begin
            b_line_reg <= st_reg.current_line;
            b_pos_reg  <= st_reg.line_position;
            b_pass_reg <= res.all_passed;
        end
    end

    // --- assertions ----------------------------------------------------------
    `TLFC_ASSERT_IMP(a_set_size, out_valid, $countones(b_mask_reg) <= 3, "more than three reports pending")
    `TLFC_ASSERT_IMP(a_done_last, out_valid && (report_code == tlfc_pkg::RC_DONE), last, "done report not last")
    `TLFC_ASSERT_NXT(a_more_follow, out_acc && !last, out_valid, "reports of a word lost")
    `TLFC_ASSERT_IMP(a_line_nonzero, out_valid, line_number != '0, "line number zero")

endmodule
